### hdl/lpgc_pkg.sv
// Shared types and constants of the linear probing group-count table.
// Used by linear_probe_group_count_core; depends on nothing else.
package lpgc_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int KEY_BITS    = 32;
    localparam int CNT_BITS    = 32;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int CFG_W       = 11;
    localparam int ADDR_W      = 3;

    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [KEY_BITS-1:0] tkey_t;
    typedef logic [CNT_BITS-1:0] cnt_t;
    typedef logic [2:0]          status_t;

    localparam status_t ST_EXISTING = 3'd0;
    localparam status_t ST_INSERTED = 3'd1;
    localparam status_t ST_FULL     = 3'd2;
    localparam status_t ST_BAD_HOME = 3'd3;
    localparam status_t ST_RESERVED = 3'd4;

    localparam logic REG_TABLE_SIZE = 1'b0;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 11'd1024;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

endpackage

### hdl/linear_probe_group_count_core.sv
// Group-count table with open addressing and linear probing over one slot memory.
// Depends on lpgc_pkg.
//
// Usage: the input channel (key, home_slot, last_in_batch) and the output channel
// (slot, key_count, status, last_of_batch) use valid and stall; a word moves at a
// rising edge with valid high and stall low. Every input word gives exactly one
// output word. The APB port holds table_size at byte address 0.
// Sequencing: a reserved key or a bad home slot has its result loaded at the accepting
// edge, so it is offered in the next cycle, and the block stays idle so the next word
// can be taken as that result leaves. Otherwise the sequencer walks the probe chain
// through the single read port of the slot memory, with a read step (address) and a
// check step (compare and write back) per probed slot; the result is loaded at the
// check step that ends the chain, and the next word is taken once back in idle.
// After reset the block clears all 1024 slots, one per cycle, and holds in_stall
// high while it does so; configuration writes are taken meanwhile.
// A result waits in the output register while out_stall is high; no new word is
// accepted until that result has gone.
module linear_probe_group_count_core
    import lpgc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       key,
    input  logic [9:0]        home_slot,
    input  logic              last_in_batch,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [9:0]        slot,
    output logic [31:0]       key_count,
    output status_t           status,
    output logic              last_of_batch
);

    state_t            state_reg, state_next;
    idx_t              pos_reg, pos_next;
    size_t             probe_reg, probe_next;
    idx_t              clr_reg, clr_next;
    tkey_t             key_reg, key_next;
    logic              last_reg, last_next;
    logic [CFG_W-1:0]  size_reg;
    logic              out_valid_reg, out_valid_next;
    logic [9:0]        slot_reg, slot_next;
    cnt_t              cnt_reg, cnt_next;
    status_t           status_reg, status_next;
    logic              lob_reg, lob_next;

    logic [KEY_BITS+CNT_BITS-1:0] mem [TABLE_SLOTS];
    logic [KEY_BITS+CNT_BITS-1:0] rd_data_reg;
    logic                         we;
    idx_t                         waddr;
    logic [KEY_BITS+CNT_BITS-1:0] wdata;

    size_t eff_size;
    tkey_t in_key;
    tkey_t rd_key;
    cnt_t  rd_cnt;
    cnt_t  inc_cnt;
    size_t pos_inc;
    logic  accept;
    logic  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_TABLE_SIZE) ? {21'd0, size_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= TABLE_SIZE_RESET;
        end
        else if (cfg_write && paddr[2] == REG_TABLE_SIZE)
        begin
            size_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_size = SIZE_W'(1);
        end
        else if (32'(size_reg) > 32'(TABLE_SLOTS))
        begin
            eff_size = SIZE_W'(TABLE_SLOTS);
        end
        else
        begin
            eff_size = SIZE_W'(size_reg);
        end
    end

    assign in_stall = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;
    assign in_key   = key[KEY_BITS-1:0];
    assign rd_key   = rd_data_reg[KEY_BITS-1:0];
    assign rd_cnt   = rd_data_reg[KEY_BITS +: CNT_BITS];
    assign inc_cnt  = (rd_cnt == '1) ? rd_cnt : rd_cnt + CNT_BITS'(1);
    assign pos_inc  = SIZE_W'(pos_reg) + SIZE_W'(1);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[pos_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        probe_next     = probe_reg;
        clr_next       = clr_reg;
        key_next       = key_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && out_stall;
        slot_next      = slot_reg;
        cnt_next       = cnt_reg;
        status_next    = status_reg;
        lob_next       = lob_reg;
        we             = 1'b0;
        waddr          = pos_reg;
        wdata          = '0;

        case (state_reg)
            S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == idx_t'(TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next   = in_key;
                    last_next  = last_in_batch;
                    pos_next   = IDX_W'(home_slot);
                    probe_next = '0;
                    if (in_key == '0)
                    begin
                        out_valid_next = 1'b1;
                        slot_next      = '0;
                        cnt_next       = '0;
                        status_next    = ST_RESERVED;
                        lob_next       = last_in_batch;
                    end
                    else if (32'(home_slot) >= 32'(eff_size))
                    begin
                        out_valid_next = 1'b1;
                        slot_next      = '0;
                        cnt_next       = '0;
                        status_next    = ST_BAD_HOME;
                        lob_next       = last_in_batch;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                lob_next = last_reg;
                if (rd_key == key_reg)
                begin
                    we             = 1'b1;
                    wdata          = {inc_cnt, key_reg};
                    out_valid_next = 1'b1;
                    slot_next      = 10'(pos_reg);
                    cnt_next       = inc_cnt;
                    status_next    = ST_EXISTING;
                    state_next     = S_IDLE;
                end
                else if (rd_key == '0)
                begin
                    we             = 1'b1;
                    wdata          = {CNT_BITS'(1), key_reg};
                    out_valid_next = 1'b1;
                    slot_next      = 10'(pos_reg);
                    cnt_next       = CNT_BITS'(1);
                    status_next    = ST_INSERTED;
                    state_next     = S_IDLE;
                end
                else if (probe_reg + SIZE_W'(1) == eff_size)
                begin
                    out_valid_next = 1'b1;
                    slot_next      = '0;
                    cnt_next       = '0;
                    status_next    = ST_FULL;
                    state_next     = S_IDLE;
                end
                else
                begin
                    probe_next = probe_reg + SIZE_W'(1);
                    pos_next   = (pos_inc >= eff_size) ? '0 : pos_inc[IDX_W-1:0];
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        probe_reg  <= probe_next;
        key_reg    <= key_next;
        last_reg   <= last_next;
        slot_reg   <= slot_next;
        cnt_reg    <= cnt_next;
        status_reg <= status_next;
        lob_reg    <= lob_next;
    end

    assign out_valid     = out_valid_reg;
    assign slot          = slot_reg;
    assign key_count     = cnt_reg;
    assign status        = status_reg;
    assign last_of_batch = lob_reg;

`ifndef SYNTH
    a_check_exits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |=> state_reg == S_IDLE || state_reg == S_READ)
        else $error("probe step left to an unexpected state");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_CHECK) || $past(in_valid && !in_stall))
        else $error("result appeared without a finished probe or an accepted word");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> SIZE_W'(pos_reg) < eff_size && probe_reg < eff_size)
        else $error("probe position outside the table in use");

    a_busy_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ || state_reg == S_CHECK || state_reg == S_CLEAR |-> in_stall)
        else $error("input not stalled while the sequencer is busy");
`endif

endmodule
